[sv/pkhv_pkg.sv]
package pkhv_pkg;

  localparam int unsigned HdrBytes = 10;
  localparam int unsigned IdxW     = 4;

  localparam logic [7:0]  MagicReset = 8'hBE;
  localparam logic [31:0] SumLowInit = 32'd1;
  localparam logic [31:0] SumHighInit = 32'd0;

  // header byte positions
  localparam logic [IdxW-1:0] HdrIdxMagic   = 4'd0;
  localparam logic [IdxW-1:0] HdrIdxKind    = 4'd1;
  localparam logic [IdxW-1:0] HdrIdxHsumHi  = 4'd2;
  localparam logic [IdxW-1:0] HdrIdxHsumLo  = 4'd3;
  localparam logic [IdxW-1:0] HdrIdxDsumHi  = 4'd4;
  localparam logic [IdxW-1:0] HdrIdxDsumLo  = 4'd5;
  localparam logic [IdxW-1:0] HdrIdxLen3    = 4'd6;
  localparam logic [IdxW-1:0] HdrIdxLen2    = 4'd7;
  localparam logic [IdxW-1:0] HdrIdxLen1    = 4'd8;
  localparam logic [IdxW-1:0] HdrIdxLast    = IdxW'(HdrBytes - 1);

  typedef enum logic {
    PhaseHeader  = 1'b0,
    PhasePayload = 1'b1
  } phase_e;

  typedef struct packed {
    logic        packet_ok;
    logic        magic_ok;
    logic        header_sum_ok;
    logic        data_sum_ok;
    logic [7:0]  packet_kind;
    logic [31:0] payload_length;
  } result_t;

  // fold the two running sums into the 16-bit check value
  function automatic logic [15:0] fold_sum(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    return s[31:16] ^ s[15:0];
  endfunction

endpackage

[sv/pkhv_core.sv]
module pkhv_core import pkhv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] expected_magic_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [31:0]     sum_low_q, sum_low_d;
  logic [31:0]     sum_high_q, sum_high_d;
  logic [7:0]      magic_q, magic_d;
  logic [7:0]      kind_q, kind_d;
  logic [15:0]     hsum_q, hsum_d;
  logic [15:0]     dsum_q, dsum_d;
  logic [31:0]     len_q, len_d;
  logic [31:0]     left_q, left_d;

  logic [7:0]  add_byte;
  logic [31:0] acc_low, acc_high;
  logic [15:0] folded;
  logic        mok, hok, dok;

  // header checksum bytes enter the header sum as zero
  assign add_byte = (phase_q == PhaseHeader &&
                     (idx_q == HdrIdxHsumHi || idx_q == HdrIdxHsumLo)) ? 8'd0 : data_byte_i;
  assign acc_low  = sum_low_q + {24'd0, add_byte};
  assign acc_high = sum_high_q + acc_low;
  assign folded   = fold_sum(acc_low, acc_high);

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    sum_low_d   = acc_low;
    sum_high_d  = acc_high;
    magic_d     = magic_q;
    kind_d      = kind_q;
    hsum_d      = hsum_q;
    dsum_d      = dsum_q;
    len_d       = len_q;
    left_d      = left_q;
    res_valid_o = 1'b0;
    mok         = (magic_q == expected_magic_i);
    hok         = (folded == hsum_q);
    dok         = (folded == dsum_q);
    res_o       = '{packet_ok: 1'b0, magic_ok: 1'b0, header_sum_ok: 1'b0,
                    data_sum_ok: 1'b0, packet_kind: kind_q, payload_length: len_q};
    unique case (phase_q)
      PhasePayload: begin
        left_d = left_q - 32'd1;
        if (left_d == 32'd0) begin
          res_valid_o = 1'b1;
          res_o.packet_ok     = dok;
          res_o.magic_ok      = 1'b1;
          res_o.header_sum_ok = 1'b1;
          res_o.data_sum_ok   = dok;
          phase_d    = PhaseHeader;
          idx_d      = HdrIdxMagic;
          sum_low_d  = SumLowInit;
          sum_high_d = SumHighInit;
        end
      end
      default: begin
        unique case (idx_q)
          HdrIdxMagic:  magic_d = data_byte_i;
          HdrIdxKind:   kind_d = data_byte_i;
          HdrIdxHsumHi: hsum_d = {data_byte_i, 8'd0};
          HdrIdxHsumLo: hsum_d = {hsum_q[15:8], data_byte_i};
          HdrIdxDsumHi: dsum_d = {data_byte_i, 8'd0};
          HdrIdxDsumLo: dsum_d = {dsum_q[15:8], data_byte_i};
          HdrIdxLen3:   len_d = {data_byte_i, 24'd0};
          HdrIdxLen2:   len_d = {len_q[31:24], data_byte_i, 16'd0};
          HdrIdxLen1:   len_d = {len_q[31:16], data_byte_i, 8'd0};
          default:      len_d = {len_q[31:8], data_byte_i};
        endcase
        if (idx_q < HdrIdxLast) begin
          idx_d = idx_q + IdxW'(1);
        end else begin
          idx_d      = HdrIdxMagic;
          sum_low_d  = SumLowInit;
          sum_high_d = SumHighInit;
          res_o.payload_length = len_d;
          if (!(mok && hok)) begin
            // bad header: report now, next byte starts a new header
            res_valid_o = 1'b1;
            res_o.magic_ok      = mok;
            res_o.header_sum_ok = hok;
          end else if (len_d == 32'd0) begin
            res_valid_o = 1'b1;
            res_o.packet_ok     = 1'b1;
            res_o.magic_ok      = 1'b1;
            res_o.header_sum_ok = 1'b1;
            res_o.data_sum_ok   = 1'b1;
          end else begin
            left_d  = len_d;
            phase_d = PhasePayload;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhaseHeader;
      idx_q      <= HdrIdxMagic;
      sum_low_q  <= SumLowInit;
      sum_high_q <= SumHighInit;
      magic_q    <= 8'd0;
      kind_q     <= 8'd0;
      hsum_q     <= 16'd0;
      dsum_q     <= 16'd0;
      len_q      <= 32'd0;
      left_q     <= 32'd0;
    end else if (advance_i) begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      sum_low_q  <= sum_low_d;
      sum_high_q <= sum_high_d;
      magic_q    <= magic_d;
      kind_q     <= kind_d;
      hsum_q     <= hsum_d;
      dsum_q     <= dsum_d;
      len_q      <= len_d;
      left_q     <= left_d;
    end
  end

endmodule

[sv/packet_header_and_payload_verifier.sv]
// Checks a byte stream of packets: a 10-byte header (magic, kind, header
// checksum, data checksum, 32-bit length, all big-endian) followed by the
// payload. One byte per transfer is taken every clock cycle while the result
// side keeps up. The deciding byte (the tenth header byte, or the last
// payload byte) goes from the input register through the single pass of the
// checksum datapath (two running 32-bit adds and the fold) into the result
// register, which sets rate and latency. A failed magic or header checksum is
// reported at once and the next byte starts a new header. The user must write
// expected_magic through cfg_we_i/cfg_wdata_i only while idle (not enforced).
module packet_header_and_payload_verifier import pkhv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        packet_ok_o,
  output logic        magic_ok_o,
  output logic        header_sum_ok_o,
  output logic        data_sum_ok_o,
  output logic [7:0]  packet_kind_o,
  output logic [31:0] payload_length_o
);

  logic [7:0] magic_cfg_q;
  logic       byte_valid_q;
  logic [7:0] byte_q;
  logic       advance;
  logic       res_valid;
  result_t    res;
  logic       out_valid_q;
  result_t    out_q;

  // held byte moves on when the result register is free or draining
  assign advance    = byte_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !byte_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_cfg_q <= MagicReset;
    end else if (cfg_we_i) begin
      magic_cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      byte_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
    end
  end

  pkhv_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .data_byte_i      (byte_q),
    .expected_magic_i (magic_cfg_q),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign packet_ok_o      = out_q.packet_ok;
  assign magic_ok_o       = out_q.magic_ok;
  assign header_sum_ok_o  = out_q.header_sum_ok;
  assign data_sum_ok_o    = out_q.data_sum_ok;
  assign packet_kind_o    = out_q.packet_kind;
  assign payload_length_o = out_q.payload_length;

endmodule
